### rtl/crt_pkg.sv
// crt_pkg: request codes, status codes and payload structs of the client route table.
// No dependencies. Used by crt_cam, crt_resolve and client_route_table.

package crt_pkg;

  typedef enum logic [1:0] {
    REQ_REGISTER  = 2'd0,
    REQ_REMOVE_FD = 2'd1,
    REQ_REMOVE_ID = 2'd2,
    REQ_LOOKUP    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ID_PRESENT = 3'd1,
    ST_FD_PRESENT = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  localparam int FD_W = 16;
  localparam int ID_W = 32;

  typedef struct packed {
    req_type_t         req_type;
    logic [FD_W-1:0]   client_fd;
    logic [ID_W-1:0]   src_id;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [FD_W-1:0]   found_fd;
  } result_t;

endpackage

### rtl/crt_cam.sv
// crt_cam: entry storage of the route table with parallel handle and identifier compare.
// Depends on crt_pkg. Updated by set/clear masks from crt_resolve.

module crt_cam #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  crt_pkg::request_t           req,
  input  logic                        wr_en,
  input  logic [TABLE_ENTRIES-1:0]    set_mask,
  input  logic [TABLE_ENTRIES-1:0]    clr_mask,
  output logic [TABLE_ENTRIES-1:0]    valid,
  output logic [TABLE_ENTRIES-1:0]    id_match,
  output logic [TABLE_ENTRIES-1:0]    fd_match,
  output logic [crt_pkg::FD_W-1:0]    found_fd
);

  logic [crt_pkg::FD_W-1:0] entry_handle [TABLE_ENTRIES];
  logic [crt_pkg::ID_W-1:0] entry_ident  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_next;

  always_comb begin
    found_fd = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      id_match[i] = valid[i] && (entry_ident[i] == req.src_id);
      fd_match[i] = valid[i] && (entry_handle[i] == req.client_fd);
      // at most one identifier hit, so an OR picks the paired handle
      found_fd    = found_fd | (entry_handle[i] & {crt_pkg::FD_W{id_match[i]}});
    end
  end

  assign valid_next = (valid & ~clr_mask) | set_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (wr_en && set_mask[i]) begin
        entry_handle[i] <= req.client_fd;
        entry_ident[i]  <= req.src_id;
      end
    end
  end

`ifndef SYNTHESIS
  a_id_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(id_match))
    else $error("more than one entry holds the identifier");
  a_fd_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(fd_match))
    else $error("more than one entry holds the handle");
  a_set_free: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ($onehot0(set_mask) && ((set_mask & valid) == '0)))
    else $error("register targets a busy slot or several slots");
  a_set_valid: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (|set_mask)) |=> ((valid & $past(set_mask)) != '0))
    else $error("registered slot not marked valid");
`endif

endmodule

### rtl/crt_resolve.sv
// crt_resolve: decides status, lookup result and table update for one request.
// Depends on crt_pkg. Consumes the compare vectors of crt_cam.

module crt_resolve #(
  parameter int TABLE_ENTRIES = 16
) (
  input  crt_pkg::request_t           req,
  input  logic [TABLE_ENTRIES-1:0]    valid,
  input  logic [TABLE_ENTRIES-1:0]    id_match,
  input  logic [TABLE_ENTRIES-1:0]    fd_match,
  input  logic [crt_pkg::FD_W-1:0]    found_fd,
  output logic [TABLE_ENTRIES-1:0]    set_mask,
  output logic [TABLE_ENTRIES-1:0]    clr_mask,
  output crt_pkg::result_t            result
);

  logic [TABLE_ENTRIES-1:0] free;
  logic [TABLE_ENTRIES-1:0] first_free;
  logic                     id_hit;
  logic                     fd_hit;

  assign free       = ~valid;
  // isolate lowest set bit: lowest-numbered free slot
  assign first_free = free & (~free + TABLE_ENTRIES'(1));
  assign id_hit     = |id_match;
  assign fd_hit     = |fd_match;

  always_comb begin
    set_mask        = '0;
    clr_mask        = '0;
    result.status   = crt_pkg::ST_OK;
    result.found_fd = '0;
    case (req.req_type)
      crt_pkg::REQ_REGISTER: begin
        if (id_hit) begin
          result.status = crt_pkg::ST_ID_PRESENT;
        end else if (fd_hit) begin
          result.status = crt_pkg::ST_FD_PRESENT;
        end else if (free == '0) begin
          result.status = crt_pkg::ST_FULL;
        end else begin
          set_mask = first_free;
        end
      end
      crt_pkg::REQ_REMOVE_FD: begin
        if (fd_hit) clr_mask = fd_match;
        else        result.status = crt_pkg::ST_NOT_FOUND;
      end
      crt_pkg::REQ_REMOVE_ID: begin
        if (id_hit) clr_mask = id_match;
        else        result.status = crt_pkg::ST_NOT_FOUND;
      end
      crt_pkg::REQ_LOOKUP: begin
        if (id_hit) result.found_fd = found_fd;
        else        result.status   = crt_pkg::ST_NOT_FOUND;
      end
      default: begin
        result.status = crt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

endmodule

### rtl/client_route_table.sv
// client_route_table: top level, request register, table and result register.
// Depends on crt_pkg, crt_cam and crt_resolve.
//
//  channel | dir | tdata                                 | tuser
//  s_*     | in  | client_fd[15:0], src_id[47:16]        | req_type[1:0]
//  m_*     | out | status[2:0], found_fd[18:3], zero pad | -
//
// One request per cycle while s_tready is high; results come from a result register.
// The table update and the result register load share one edge, so the next
// request already compares against the updated entries.
// rst empties the table by clearing the valid bits.
// A stalled result holds the request register; s_tready drops only when both are full.

module client_route_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // client_fd[15:0], src_id[47:16]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[2:0], found_fd[18:3], zero [23:19]
);

  logic                       req_valid;
  crt_pkg::request_t          req;
  logic                       advance;
  logic                       commit;
  logic [TABLE_ENTRIES-1:0]   valid;
  logic [TABLE_ENTRIES-1:0]   id_match;
  logic [TABLE_ENTRIES-1:0]   fd_match;
  logic [crt_pkg::FD_W-1:0]   found_fd;
  logic [TABLE_ENTRIES-1:0]   set_mask;
  logic [TABLE_ENTRIES-1:0]   clr_mask;
  crt_pkg::result_t           result_next;
  crt_pkg::result_t           result;

  assign advance  = !m_tvalid || m_tready;
  assign commit   = req_valid && advance;
  assign s_tready = advance || !req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req.req_type  <= crt_pkg::req_type_t'(s_tuser);
      req.client_fd <= s_tdata[15:0];
      req.src_id    <= s_tdata[47:16];
    end
  end

  crt_cam #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_cam (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr_en    (commit),
    .set_mask (set_mask),
    .clr_mask (clr_mask),
    .valid    (valid),
    .id_match (id_match),
    .fd_match (fd_match),
    .found_fd (found_fd)
  );

  crt_resolve #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_resolve (
    .req      (req),
    .valid    (valid),
    .id_match (id_match),
    .fd_match (fd_match),
    .found_fd (found_fd),
    .set_mask (set_mask),
    .clr_mask (clr_mask),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result <= result_next;
    end
  end

  assign m_tdata = {5'b0, result.found_fd, result.status};

endmodule

### dv/client_route_table_tb.sv
// client_route_table_tb: self-checking testbench for the client route table.
// Needs crt_pkg and client_route_table; a scoreboard class predicts every answer,
// plain tasks drive the request stream and the receiver applies back-pressure.
`timescale 1ns / 100ps

module client_route_table_tb;

  localparam int ENTRIES   = 16;
  localparam int POOL_SIZE = 24;
  localparam int N_RANDOM  = 800;

  class route_table_model;
    bit                       slot_used [ENTRIES];
    logic [crt_pkg::FD_W-1:0] slot_fd   [ENTRIES];
    logic [crt_pkg::ID_W-1:0] slot_id   [ENTRIES];
    crt_pkg::result_t         pending_answers[$];
    int errors;
    int checked;
    int op_count[4];
    int status_count[5];

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_fd[i]   = '0;
        slot_id[i]   = '0;
      end
      errors  = 0;
      checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    // Applies one request to the shadow table and returns the answer it should give.
    function crt_pkg::result_t predict_answer(crt_pkg::request_t r);
      int               id_slot;
      int               fd_slot;
      int               free_slot;
      crt_pkg::result_t a;
      id_slot   = -1;
      fd_slot   = -1;
      free_slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_id[i] == r.src_id) id_slot = i;
        if (slot_used[i] && slot_fd[i] == r.client_fd) fd_slot = i;
        if (!slot_used[i]) free_slot = i;
      end
      a.status   = crt_pkg::ST_OK;
      a.found_fd = '0;
      case (r.req_type)
        crt_pkg::REQ_REGISTER: begin
          if (id_slot >= 0) a.status = crt_pkg::ST_ID_PRESENT;
          else if (fd_slot >= 0) a.status = crt_pkg::ST_FD_PRESENT;
          else if (free_slot < 0) a.status = crt_pkg::ST_FULL;
          else begin
            slot_used[free_slot] = 1'b1;
            slot_fd[free_slot]   = r.client_fd;
            slot_id[free_slot]   = r.src_id;
          end
        end
        crt_pkg::REQ_REMOVE_FD: begin
          if (fd_slot < 0) a.status = crt_pkg::ST_NOT_FOUND;
          else slot_used[fd_slot] = 1'b0;
        end
        crt_pkg::REQ_REMOVE_ID: begin
          if (id_slot < 0) a.status = crt_pkg::ST_NOT_FOUND;
          else slot_used[id_slot] = 1'b0;
        end
        default: begin
          if (id_slot < 0) a.status = crt_pkg::ST_NOT_FOUND;
          else a.found_fd = slot_fd[id_slot];
        end
      endcase
      return a;
    endfunction

    function void note_request(crt_pkg::request_t r);
      crt_pkg::result_t a;
      a = predict_answer(r);
      op_count[int'(r.req_type)]++;
      status_count[int'(a.status)]++;
      pending_answers.push_back(a);
    endfunction

    function void check_result(logic [2:0] st, logic [crt_pkg::FD_W-1:0] fd);
      crt_pkg::result_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d found_fd %h",
                 $time, st, fd);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      checked++;
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
        errors++;
      end
      if (fd !== want.found_fd) begin
        $display("%0t: found_fd mismatch, expected %h, actual %h", $time, want.found_fd, fd);
        errors++;
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  route_table_model model = new();

  bit idle_on       = 1'b1;
  bit stall_request = 1'b0;

  logic [crt_pkg::FD_W-1:0] fd_pool[POOL_SIZE];
  logic [crt_pkg::ID_W-1:0] id_pool[POOL_SIZE];

  client_route_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic crt_pkg::request_t make_req(crt_pkg::req_type_t op,
                                                 logic [crt_pkg::FD_W-1:0] fd,
                                                 logic [crt_pkg::ID_W-1:0] id);
    crt_pkg::request_t r;
    r.req_type  = op;
    r.client_fd = fd;
    r.src_id    = id;
    return r;
  endfunction

  // Offers one request and returns at the edge of its transaction.
  task automatic send_request(input crt_pkg::request_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.req_type;
    s_tdata  <= {r.src_id, r.client_fd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.note_request(r);
  endtask

  // Fill-biased segments push the table toward full, drain-biased ones empty it.
  function automatic crt_pkg::request_t random_req(bit fill_bias);
    int                 w;
    crt_pkg::req_type_t op;
    crt_pkg::request_t  r;
    w = $urandom_range(0, 99);
    if (fill_bias)
      op = (w < 55) ? crt_pkg::REQ_REGISTER : (w < 65) ? crt_pkg::REQ_REMOVE_FD :
           (w < 75) ? crt_pkg::REQ_REMOVE_ID : crt_pkg::REQ_LOOKUP;
    else
      op = (w < 15) ? crt_pkg::REQ_REGISTER : (w < 45) ? crt_pkg::REQ_REMOVE_FD :
           (w < 75) ? crt_pkg::REQ_REMOVE_ID : crt_pkg::REQ_LOOKUP;
    r.req_type  = op;
    r.client_fd = ($urandom_range(0, 99) < 15) ? crt_pkg::FD_W'($urandom)
                                               : fd_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.src_id    = ($urandom_range(0, 99) < 15) ? crt_pkg::ID_W'($urandom)
                                               : id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return r;
  endfunction

  // Result side: checks each transaction and drops tready in bursts or one long stall.
  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) model.check_result(m_tdata[2:0], m_tdata[18:3]);
      if (hold_left == 0 && stall_request) begin
        hold_left     = 120;
        stall_request = 1'b0;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    fd_pool[0] = '0;
    fd_pool[1] = '1;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      fd_pool[i] = crt_pkg::FD_W'($urandom);
      id_pool[i] = crt_pkg::ID_W'($urandom);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, refusal order, misses, then a full table and a freed slot reused
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0000, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0001, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'hFFFF, 32'h0000_0005));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0000, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_LOOKUP,    16'h0000, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_LOOKUP,    16'h0000, 32'hFFFF_FFFF));
    send_request(make_req(crt_pkg::REQ_LOOKUP,    16'h0000, 32'h0000_0123));
    send_request(make_req(crt_pkg::REQ_REMOVE_FD, 16'h1234, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_REMOVE_ID, 16'h0000, 32'h0000_0077));
    send_request(make_req(crt_pkg::REQ_REMOVE_FD, 16'hFFFF, 32'h0000_0000));
    send_request(make_req(crt_pkg::REQ_REMOVE_ID, 16'h0000, 32'h0000_0000));
    for (int i = 0; i < ENTRIES; i++)
      send_request(make_req(crt_pkg::REQ_REGISTER, 16'h0100 + i, 32'h8000_0000 + i));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0200, 32'h0000_1234));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0100, 32'h0000_5555));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h0300, 32'h8000_0000));
    send_request(make_req(crt_pkg::REQ_REMOVE_ID, 16'h0000, 32'h8000_0003));
    send_request(make_req(crt_pkg::REQ_REGISTER,  16'h5A5A, 32'hA5A5_A5A5));
    send_request(make_req(crt_pkg::REQ_LOOKUP,    16'h0000, 32'hA5A5_A5A5));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) stall_request = 1'b1;
      if (n == N_RANDOM - 150) idle_on = 1'b0;
      send_request(random_req(((n / 100) % 2) == 0));
    end
    s_tvalid <= 1'b0;

    while (model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: register %0d, remove by fd %0d, remove by id %0d, lookup %0d",
             model.checked, model.op_count[crt_pkg::REQ_REGISTER],
             model.op_count[crt_pkg::REQ_REMOVE_FD],
             model.op_count[crt_pkg::REQ_REMOVE_ID], model.op_count[crt_pkg::REQ_LOOKUP]);
    $display("answers: ok %0d, id taken %0d, fd taken %0d, full %0d, not found %0d",
             model.status_count[crt_pkg::ST_OK], model.status_count[crt_pkg::ST_ID_PRESENT],
             model.status_count[crt_pkg::ST_FD_PRESENT], model.status_count[crt_pkg::ST_FULL],
             model.status_count[crt_pkg::ST_NOT_FOUND]);
    if (model.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/crt_pkg.sv
rtl/crt_cam.sv
rtl/crt_resolve.sv
rtl/client_route_table.sv
dv/client_route_table_tb.sv
